FILE: src/fqks_pkg.sv
// Shared types, constants and helpers for the key-search queue.
`timescale 1ns / 1ps
`default_nettype none

package fqks_pkg;

	// Queue geometry
	localparam int DEPTH     = 16;
	localparam int KEY_WIDTH = 32;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	// Field widths on the stream ports
	localparam int OKEY_W = 32;
	localparam int POS_W  = 4;
	localparam int OCNT_W = 5;

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic signed [OKEY_W-1:0]    okey_t;
	typedef logic [PTR_W-1:0]            ptr_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// One result transaction, handed from the engine to the output register
	typedef struct packed {
		status_t           status;
		okey_t             popped_key;
		logic              found;
		logic [POS_W-1:0]  found_position;
		logic [OCNT_W-1:0] entry_count;
		logic              nonempty;
		okey_t             first_key;
		okey_t             last_key;
	} res_t;

	// Advance a ring pointer with wrap at the queue depth
	function automatic ptr_t ring_next(input ptr_t p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Sign extend or truncate a stored key to the port width
	function automatic okey_t key_out(input key_t k);
		return okey_t'(k);
	endfunction

endpackage

`default_nettype wire

FILE: src/fqks_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fqks_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/fqks_engine.sv
// Queue sequencer: ring pointers, key store access, search scan and result build.
`timescale 1ns / 1ps
`default_nettype none

module fqks_engine (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               in_op,
	input  wire logic [31:0]              in_key,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output fqks_pkg::res_t                res
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_POP    = 4'b0010,
		S_SEARCH = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t               state_q;
	fqks_pkg::ptr_t       head_q;
	fqks_pkg::ptr_t       tail_q;
	fqks_pkg::cnt_t       count_q;
	fqks_pkg::ptr_t       scan_slot_q;
	fqks_pkg::ptr_t       scan_idx_q;
	fqks_pkg::key_t       key_q;
	fqks_pkg::key_t       first_q;
	fqks_pkg::key_t       last_q;
	fqks_pkg::status_t    status_q;
	fqks_pkg::okey_t      popped_q;
	logic                 found_q;
	fqks_pkg::ptr_t       pos_q;

	logic                 accept;
	fqks_pkg::op_t        op;
	fqks_pkg::key_t       key_in;
	logic                 ram_we;
	fqks_pkg::ptr_t       ram_raddr;
	fqks_pkg::key_t       ram_rdata;
	logic                 scan_hit;
	logic                 scan_end;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign op       = fqks_pkg::op_t'(in_op);
	assign key_in   = fqks_pkg::key_t'(signed'(in_key));
	assign ram_we   = accept && (op == fqks_pkg::OP_PUSH) && (count_q != fqks_pkg::CNT_FULL);

	// Pick the read slot: next scan entry, head for a search, next head for a pop
	always_comb begin
		if (state_q == S_SEARCH) begin
			ram_raddr = fqks_pkg::ring_next(scan_slot_q);
		end else if (op == fqks_pkg::OP_SEARCH) begin
			ram_raddr = head_q;
		end else begin
			ram_raddr = fqks_pkg::ring_next(head_q);
		end
	end

	fqks_ram #(
		.DEPTH (fqks_pkg::DEPTH),
		.WIDTH (fqks_pkg::KEY_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (key_in),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Compare the entry that arrived this cycle; stop at the last occupied one
	assign scan_hit = (ram_rdata == key_q);
	assign scan_end = ((fqks_pkg::CNT_W'(scan_idx_q) + 1'b1) == count_q);

	// Sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			scan_slot_q <= '0;
			scan_idx_q  <= '0;
			key_q       <= '0;
			first_q     <= '0;
			last_q      <= '0;
			status_q    <= fqks_pkg::ST_OK;
			popped_q    <= '0;
			found_q     <= 1'b0;
			pos_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q    <= key_in;
						status_q <= fqks_pkg::ST_OK;
						popped_q <= '0;
						found_q  <= 1'b0;
						pos_q    <= '0;
						state_q  <= S_RESULT;
						case (op)
							fqks_pkg::OP_PUSH: begin
								if (count_q == fqks_pkg::CNT_FULL) begin
									status_q <= fqks_pkg::ST_FULL;
								end else begin
									tail_q  <= fqks_pkg::ring_next(tail_q);
									count_q <= count_q + 1'b1;
									last_q  <= key_in;
									if (count_q == '0) begin
										first_q <= key_in;
									end
								end
							end
							fqks_pkg::OP_POP: begin
								if (count_q == '0) begin
									status_q <= fqks_pkg::ST_EMPTY;
								end else begin
									popped_q <= fqks_pkg::key_out(first_q);
									head_q   <= fqks_pkg::ring_next(head_q);
									count_q  <= count_q - 1'b1;
									// fetch the new head unless the queue drains
									if (count_q != fqks_pkg::CNT_W'(1)) begin
										state_q <= S_POP;
									end
								end
							end
							fqks_pkg::OP_SEARCH: begin
								status_q <= fqks_pkg::ST_NOT_FOUND;
								if (count_q != '0) begin
									scan_slot_q <= head_q;
									scan_idx_q  <= '0;
									state_q     <= S_SEARCH;
								end
							end
							default: begin
								head_q  <= '0;
								tail_q  <= '0;
								count_q <= '0;
							end
						endcase
					end
				end
				S_POP: begin
					first_q <= ram_rdata;
					state_q <= S_RESULT;
				end
				S_SEARCH: begin
					if (scan_hit) begin
						status_q <= fqks_pkg::ST_OK;
						found_q  <= 1'b1;
						pos_q    <= scan_idx_q;
						state_q  <= S_RESULT;
					end else if (scan_end) begin
						state_q <= S_RESULT;
					end else begin
						scan_slot_q <= fqks_pkg::ring_next(scan_slot_q);
						scan_idx_q  <= scan_idx_q + 1'b1;
					end
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Build the result with a snapshot of the queue after the operation
	assign res_valid = (state_q == S_RESULT);

	always_comb begin
		res.status         = status_q;
		res.popped_key     = popped_q;
		res.found          = found_q;
		res.found_position = fqks_pkg::POS_W'(pos_q);
		res.entry_count    = fqks_pkg::OCNT_W'(count_q);
		res.nonempty       = (count_q != '0);
		res.first_key      = res.nonempty ? fqks_pkg::key_out(first_q) : '0;
		res.last_key       = res.nonempty ? fqks_pkg::key_out(last_q) : '0;
	end

endmodule

`default_nettype wire

FILE: src/fifo_queue_with_key_search.sv
// Push, clear, push into full, pop on empty and search on empty go straight to the result.
// A pop reads the key store once to fetch the new head, except when it empties the queue.
// A search compares entries from the head until a match or the last entry, at most DEPTH (16).
// Throughput: one transaction at a time; the search scan reads one entry per cycle.
// Reset: arst_n clears pointers and count at once; the key store is not cleared.
// A finished result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_key_search (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // key_in[31:0]
	input  wire logic [1:0]   s_tuser,   // opcode[1:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,   // popped_key[31:0], found[32], found_position[36:33],
	                                     // entry_count[41:37], nonempty[42],
	                                     // first_key[74:43], last_key[106:75], zero[111:107]
	output logic [1:0]        m_tuser    // status[1:0]
);

	logic            res_valid;
	logic            res_ready;
	fqks_pkg::res_t  res;
	logic            m_tvalid_q;
	fqks_pkg::res_t  m_res_q;

	fqks_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_key    (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load when empty or draining
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {5'b0,
	                   m_res_q.last_key,
	                   m_res_q.first_key,
	                   m_res_q.nonempty,
	                   m_res_q.entry_count,
	                   m_res_q.found_position,
	                   m_res_q.found,
	                   m_res_q.popped_key};

endmodule

`default_nettype wire

FILE: test/fqks_checker.sv
// Scoreboard that predicts and checks every result transaction of the key-search queue.
`timescale 1ns / 1ps
`default_nettype none

module fqks_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [31:0]  s_tdata,   // key_in[31:0]
	input  wire logic [1:0]   s_tuser,   // opcode[1:0]
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [111:0] m_tdata,   // popped_key, found, found_position, entry_count,
	                                     // nonempty, first_key, last_key, zero pad
	input  wire logic [1:0]   m_tuser,   // status[1:0]
	output int                fail_count,
	output int                pending
);

	import fqks_pkg::*;

	// Shadow copy of the queue
	key_t ring_keys [DEPTH];
	ptr_t head_ptr = '0;
	ptr_t tail_ptr = '0;
	int   entries  = 0;

	// Results still owed by the block, oldest first
	res_t owed_results [$];

	// Apply one operation to the shadow queue and return the result it should give
	function automatic res_t queue_step(input op_t op, input key_t key);
		res_t r;
		logic hit;
		ptr_t slot;
		int   i;
		r = '0;
		hit = 1'b0;
		case (op)
		OP_PUSH: begin
			if (entries == DEPTH) begin
				r.status = ST_FULL;
			end else begin
				ring_keys[tail_ptr] = key;
				tail_ptr = ptr_t'((int'(tail_ptr) + 1) % DEPTH);
				entries++;
			end
		end
		OP_POP: begin
			if (entries == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.popped_key = okey_t'(ring_keys[head_ptr]);
				head_ptr = ptr_t'((int'(head_ptr) + 1) % DEPTH);
				entries--;
			end
		end
		OP_SEARCH: begin
			// scan from the head, keep the first match
			r.status = ST_NOT_FOUND;
			for (i = 0; i < entries; i++) begin
				slot = ptr_t'((int'(head_ptr) + i) % DEPTH);
				if (!hit && ring_keys[slot] == key) begin
					hit = 1'b1;
					r.status = ST_OK;
					r.found = 1'b1;
					r.found_position = POS_W'(i);
				end
			end
		end
		default: begin
			head_ptr = '0;
			tail_ptr = '0;
			entries = 0;
		end
		endcase

		// snapshot after the operation
		r.entry_count = OCNT_W'(entries);
		if (entries != 0) begin
			r.nonempty = 1'b1;
			r.first_key = okey_t'(ring_keys[head_ptr]);
			r.last_key = okey_t'(ring_keys[ptr_t'((int'(tail_ptr) + DEPTH - 1) % DEPTH)]);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s mismatch: got %h, expected %h", field, got, want));
	endtask

	// Compare the result transaction, then record the new request
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			head_ptr = '0;
			tail_ptr = '0;
			entries = 0;
			owed_results.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result transaction with no request outstanding");
				end else begin
					want = owed_results.pop_front();
					check_field("status", m_tuser, want.status);
					check_field("popped_key", m_tdata[31:0], want.popped_key);
					check_field("found", m_tdata[32], want.found);
					check_field("found_position", m_tdata[36:33], want.found_position);
					check_field("entry_count", m_tdata[41:37], want.entry_count);
					check_field("nonempty", m_tdata[42], want.nonempty);
					check_field("first_key", m_tdata[74:43], want.first_key);
					check_field("last_key", m_tdata[106:75], want.last_key);
					check_field("pad bits", m_tdata[111:107], 32'd0);
				end
			end
			if (s_tvalid && s_tready)
				owed_results.push_back(queue_step(op_t'(s_tuser), key_t'(s_tdata)));
			pending = owed_results.size();
		end
	end

endmodule

`default_nettype wire

FILE: test/tb_fifo_queue_with_key_search.sv
// Stimulus and verdict for the key-search queue, checked by fqks_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_fifo_queue_with_key_search;

	import fqks_pkg::*;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int DRAIN_CYCLES = 24;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata  = '0;   // key_in[31:0]
	logic [1:0]   s_tuser  = OP_PUSH;   // opcode[1:0]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;   // popped_key, found, found_position, entry_count,
	                         // nonempty, first_key, last_key, zero pad
	logic [1:0]   m_tuser;   // status[1:0]

	int fail_count;
	int pending;
	int cycle_count = 0;
	int items_sent  = 0;
	int tx_mode     = 1;
	int rx_mode     = 1;
	int hold_len    = 0;

	logic [31:0] key_pool [8];

	fifo_queue_with_key_search uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fqks_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("fifo_queue_with_key_search test failed");
			$finish;
		end
	end

	// Wait cycles before a transaction: none, uniform, or mostly none
	function automatic int draw_wait(input int mode);
		case (mode)
		0:       return 0;
		1:       return $urandom_range(0, 14);
		default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
		endcase
	endfunction

	// Mostly keys from a small pool so searches hit, else any 32-bit value
	function automatic logic [31:0] pick_key();
		return ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom;
	endfunction

	// Offer one request; called and returning just after a falling edge
	task automatic send_item(input op_t op, input logic [31:0] key);
		int gap;
		gap = draw_wait(tx_mode);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= key;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	// Hold the sender until every result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// Result sink with random back-pressure and the occasional long hold-off
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_len > 0) begin
				stall = hold_len;
				hold_len = 0;
			end else begin
				stall = draw_wait(rx_mode);
			end
			repeat (stall) @(negedge clk) m_tready <= 1'b0;
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : stimulus
		logic [31:0] scan_keys [DEPTH];
		int n;
		int i;
		int r;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (i = 4; i < 8; i++)
			key_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: empty queue, key extremes, search hits at several depths, miss, clear
		send_item(OP_POP, 32'h0);
		send_item(OP_SEARCH, 32'h0);
		send_item(OP_PUSH, 32'h7fff_ffff);
		send_item(OP_PUSH, 32'h8000_0000);
		send_item(OP_PUSH, 32'h0000_0000);
		send_item(OP_PUSH, 32'hffff_ffff);
		send_item(OP_SEARCH, 32'hffff_ffff);
		send_item(OP_SEARCH, 32'h7fff_ffff);
		send_item(OP_SEARCH, 32'h8000_0000);
		send_item(OP_SEARCH, 32'h5a5a_a5a5);
		send_item(OP_POP, 32'hffff_ffff);
		send_item(OP_POP, 32'h0);
		send_item(OP_PUSH, 32'h1234_5678);
		send_item(OP_CLEAR, 32'hffff_ffff);
		send_item(OP_POP, 32'h0);
		send_item(OP_SEARCH, 32'h1234_5678);
		wait_drained();

		// Back-pressure: sink holds off while pushes keep coming, past full
		tx_mode = 0;
		hold_len = 80;
		for (i = 0; i < 24; i++)
			send_item(OP_PUSH, $urandom);
		wait_drained();
		send_item(OP_CLEAR, $urandom);

		// Random phases
		while (items_sent < RANDOM_ITEMS) begin
			tx_mode = $urandom_range(0, 2);
			rx_mode = $urandom_range(0, 2);
			r = $urandom_range(0, 3);
			if (r < 2) begin
				// clear, fill with fresh keys, then search and pop
				send_item(OP_CLEAR, $urandom);
				n = ($urandom_range(0, 2) == 0) ? DEPTH : $urandom_range(1, DEPTH);
				for (i = 0; i < n; i++) begin
					scan_keys[i] = ($urandom_range(0, 3) == 0) ? pick_key() : $urandom;
					send_item(OP_PUSH, scan_keys[i]);
				end
				if (n == DEPTH) begin
					send_item(OP_PUSH, $urandom);
					send_item(OP_SEARCH, scan_keys[DEPTH-1]);
				end
				for (i = $urandom_range(3, 8); i > 0; i--)
					send_item(OP_SEARCH, ($urandom_range(0, 4) == 0) ? $urandom
						: scan_keys[$urandom_range(0, n - 1)]);
				for (i = $urandom_range(0, n); i > 0; i--)
					send_item(($urandom_range(0, 2) == 0) ? OP_SEARCH : OP_POP,
						scan_keys[$urandom_range(0, n - 1)]);
			end else if (r == 2) begin
				// mixed traffic
				for (i = $urandom_range(20, 40); i > 0; i--) begin
					n = $urandom_range(0, 99);
					if (n < 40)
						send_item(OP_PUSH, pick_key());
					else if (n < 70)
						send_item(OP_POP, $urandom);
					else if (n < 95)
						send_item(OP_SEARCH, pick_key());
					else
						send_item(OP_CLEAR, $urandom);
				end
			end else begin
				// overfill, probe, then drain past empty
				for (i = 0; i < DEPTH + 2; i++)
					send_item(OP_PUSH, pick_key());
				for (i = 0; i < 4; i++)
					send_item(OP_SEARCH, pick_key());
				for (i = 0; i < DEPTH + 2; i++)
					send_item(OP_POP, $urandom);
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("fifo_queue_with_key_search test passed");
		else
			$display("fifo_queue_with_key_search test failed");
		$finish;
	end

endmodule

`default_nettype wire
